FILE: design/task_scheduler_with_pid_pool_top_assert.svh
// Assertion macros used by the scheduler datapath, tsp_dp.
`ifndef TASK_SCHEDULER_WITH_PID_POOL_TOP_ASSERT_SVH
`define TASK_SCHEDULER_WITH_PID_POOL_TOP_ASSERT_SVH

// Same-cycle implication.
`define TSP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsp assertion failed");

// Next-cycle implication.
`define TSP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsp assertion failed");

`endif

FILE: design/tsp_pkg.sv
`default_nettype none
package tsp_pkg;

  localparam int PID_W = 11;

  typedef struct packed {
    logic [2:0]       action;
    logic [PID_W-1:0] target_pid;
    logic [7:0]       priority_req;
    logic [1:0]       block_kind;
    logic             reschedule;
  } in_t;

  typedef struct packed {
    logic [PID_W-1:0] result_pid;
    logic [PID_W-1:0] previous_pid;
    logic             switched;
    logic [1:0]       outcome;
  } out_t;

  localparam logic [2:0] ACT_CREATE  = 3'd0;
  localparam logic [2:0] ACT_PREEMPT = 3'd1;
  localparam logic [2:0] ACT_YIELD   = 3'd2;
  localparam logic [2:0] ACT_BLOCK   = 3'd3;
  localparam logic [2:0] ACT_UNBLOCK = 3'd4;
  localparam logic [2:0] ACT_EXIT    = 3'd5;

  localparam logic [2:0] ST_RUNNING = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd1;
  localparam logic [2:0] ST_BLOCKED = 3'd2;
  localparam logic [2:0] ST_HANGING = 3'd4;
  localparam logic [2:0] ST_DIED    = 3'd5;

  localparam logic [1:0] KIND_BAD = 2'd3;

  localparam logic [1:0] OUTC_OK   = 2'd0;
  localparam logic [1:0] OUTC_FULL = 2'd1;
  localparam logic [1:0] OUTC_BAD  = 2'd2;
  localparam logic [1:0] OUTC_NONE = 2'd3;

  localparam logic REG_IDLE_PID = 1'b0;

  typedef enum logic [1:0] {RD_TGT, RD_CUR, RD_RUN, RD_IDLE} rd_sel_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_SCAN, S_CHECK, S_RS_RD, S_RS_CK,
    S_DS_RD, S_DS_IDLE, S_DS_HEAD, S_DS_POP, S_FINISH
  } state_t;

  typedef struct packed {
    logic    accept;
    logic    clr_step;
    logic    scan_start;
    logic    scan_step;
    logic    create_commit;
    logic    rd_en;
    rd_sel_t rd_sel;
    logic    err;
    logic    requeue;
    logic    reload;
    logic    block_commit;
    logic    push;
    logic    exit_commit;
    logic    ds_start;
    logic    none_run;
    logic    head_rd;
    logic    pop;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic [2:0] act;
    logic [1:0] kind;
    logic       resched;
    logic       live;
    logic       run_ok;
    logic       wait_ok;
    logic       cnt_zero;
    logic       found;
    logic       scan_last;
    logic       clr_done;
    logic       out_busy;
  } sts_t;

endpackage
`default_nettype wire

FILE: design/tsp_ctrl.sv
`default_nettype none
module tsp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tsp_pkg::sts_t sts,
  output tsp_pkg::cmd_t      cmd
);
  import tsp_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts.act) inside
          ACT_CREATE: state_nxt = S_SCAN;
          ACT_PREEMPT, ACT_YIELD, ACT_BLOCK, ACT_UNBLOCK, ACT_EXIT: state_nxt = S_CHECK;
          default: state_nxt = S_FINISH;
        endcase
      end
      S_SCAN: begin
        if (sts.found || sts.scan_last) state_nxt = S_FINISH;
      end
      S_CHECK: begin
        unique case (sts.act) inside
          ACT_PREEMPT, ACT_YIELD: state_nxt = S_DS_RD;
          ACT_BLOCK: begin
            state_nxt = (sts.kind == KIND_BAD || !sts.live) ? S_FINISH : S_DS_RD;
          end
          ACT_EXIT: begin
            state_nxt = (sts.live && sts.resched) ? S_RS_RD : S_FINISH;
          end
          default: state_nxt = S_FINISH;
        endcase
      end
      S_RS_RD:   state_nxt = S_RS_CK;
      S_RS_CK:   state_nxt = S_DS_RD;
      S_DS_RD:   state_nxt = S_DS_IDLE;
      S_DS_IDLE: state_nxt = S_DS_HEAD;
      S_DS_HEAD: state_nxt = sts.cnt_zero ? S_FINISH : S_DS_POP;
      S_DS_POP:  state_nxt = S_FINISH;
      S_FINISH: begin
        if (!sts.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_CLEAR: cmd.clr_step = 1'b1;
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      S_DECODE: begin
        unique case (sts.act) inside
          ACT_CREATE: cmd.scan_start = 1'b1;
          ACT_PREEMPT, ACT_YIELD, ACT_BLOCK: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_CUR;
          end
          ACT_UNBLOCK, ACT_EXIT: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = RD_TGT;
          end
          default: cmd.err = 1'b1;
        endcase
      end
      S_SCAN: begin
        if (sts.found) cmd.create_commit = 1'b1;
        else if (!sts.scan_last) cmd.scan_step = 1'b1;
      end
      S_CHECK: begin
        unique case (sts.act) inside
          ACT_PREEMPT, ACT_YIELD: begin
            cmd.requeue = sts.run_ok;
            cmd.reload  = (sts.act == ACT_PREEMPT);
          end
          ACT_BLOCK: begin
            if (sts.kind == KIND_BAD || !sts.live) cmd.err = 1'b1;
            else cmd.block_commit = 1'b1;
          end
          ACT_UNBLOCK: begin
            if (sts.wait_ok) cmd.push = 1'b1;
            else cmd.err = 1'b1;
          end
          ACT_EXIT: begin
            if (sts.live) cmd.exit_commit = 1'b1;
            else cmd.err = 1'b1;
          end
          default: cmd.err = 1'b1;
        endcase
      end
      S_RS_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_RUN;
      end
      S_RS_CK: begin
        cmd.requeue = sts.run_ok;
        cmd.reload  = 1'b1;
      end
      S_DS_RD: begin
        cmd.ds_start = 1'b1;
        cmd.rd_en    = 1'b1;
        cmd.rd_sel   = RD_IDLE;
      end
      S_DS_IDLE: cmd.push = sts.cnt_zero && sts.wait_ok;
      S_DS_HEAD: begin
        if (sts.cnt_zero) cmd.none_run = 1'b1;
        else cmd.head_rd = 1'b1;
      end
      S_DS_POP: cmd.pop = 1'b1;
      S_FINISH: cmd.out_load = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule
`default_nettype wire

FILE: design/tsp_dp.sv
`default_nettype none
`include "task_scheduler_with_pid_pool_top_assert.svh"
module tsp_dp #(
  parameter int MAX_TASKS = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire tsp_pkg::cmd_t             cmd,
  input  wire tsp_pkg::in_t              in_data,
  input  wire logic [tsp_pkg::PID_W-1:0] idle_pid,
  output tsp_pkg::sts_t                  sts,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output tsp_pkg::out_t                  out_data
);
  import tsp_pkg::*;

  localparam int IW        = $clog2(MAX_TASKS);
  localparam int CW        = $clog2(MAX_TASKS + 1);
  localparam int ROWS      = (MAX_TASKS + 31) / 32;
  localparam int RAW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SCW       = $clog2(ROWS + 1);
  localparam int LAST_BITS = MAX_TASKS - (ROWS - 1) * 32;
  localparam logic [31:0] LAST_MASK = 32'hFFFF_FFFF >> (32 - LAST_BITS);

  logic [31:0]      used_mem [ROWS];
  logic [2:0]       st_mem   [MAX_TASKS];
  logic [15:0]      tcb_mem  [MAX_TASKS];
  logic [IW-1:0]    nx_mem   [MAX_TASKS];
  logic [IW-1:0]    pv_mem   [MAX_TASKS];

  logic [2:0]       act_r;
  logic [PID_W-1:0] tgt_r;
  logic [7:0]       prio_r;
  logic [1:0]       kind_r;
  logic             resched_r;
  logic [PID_W-1:0] cur_r;

  logic [PID_W-1:0] run_r, run_nxt;
  logic [IW-1:0]    head_r, head_nxt, tail_r, tail_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [RAW-1:0]   clr_cnt_r;
  logic [SCW-1:0]   scan_cnt_r;
  logic [RAW-1:0]   row_rd_addr_r;

  logic [PID_W-1:0] lv_pid, lv_pid_r;
  logic [31:0]      lv_word;
  logic [IW-1:0]    lv_idx, lv_idx_r;
  logic [RAW-1:0]   lv_row, lv_row_r;
  logic [4:0]       lv_bit, lv_bit_r;
  logic             lv_in, lv_in_r;

  logic [31:0]      used_rd_r;
  logic [2:0]       st_rd_r;
  logic [15:0]      tcb_rd_r;
  logic [IW-1:0]    nx_rd_r, pv_rd_r;

  logic [31:0]      row_mask, free;
  logic [4:0]       fbit;
  logic [RAW+4:0]   fword;
  logic [IW-1:0]    found_idx;
  logic             live;

  logic             used_we, used_re;
  logic [RAW-1:0]   used_waddr, used_raddr;
  logic [31:0]      used_wdata;
  logic             st_we;
  logic [IW-1:0]    st_waddr;
  logic [2:0]       st_wdata;
  logic             tcb_we;
  logic [IW-1:0]    tcb_waddr;
  logic [15:0]      tcb_wdata;
  logic             nx_we, pv_we, lk_re;
  logic [IW-1:0]    nx_waddr, nx_wdata, pv_waddr, pv_wdata, lk_raddr;
  logic             do_append;
  logic [IW-1:0]    app_x;

  logic [PID_W-1:0] res_pid_r, res_prev_r;
  logic             res_sw_r;
  logic [1:0]       res_out_r;
  logic             out_valid_r;
  out_t             out_data_r;

  // read address for the task-table lookup
  always_comb begin
    unique case (cmd.rd_sel)
      RD_TGT:  lv_pid = tgt_r;
      RD_CUR:  lv_pid = cur_r;
      RD_RUN:  lv_pid = run_r;
      RD_IDLE: lv_pid = idle_pid;
      default: lv_pid = '0;
    endcase
    lv_word = 32'(lv_pid) - 32'd1;
    lv_idx  = IW'(lv_word);
    lv_row  = lv_word[RAW+4:5];
    lv_bit  = lv_word[4:0];
    lv_in   = (lv_pid != '0) && (32'(lv_pid) <= 32'(MAX_TASKS));
  end

  // lowest free bit of the row just read
  always_comb begin
    row_mask = (row_rd_addr_r == RAW'(ROWS - 1)) ? LAST_MASK : 32'hFFFF_FFFF;
    free     = ~used_rd_r & row_mask;
    fbit     = '0;
    for (int b = 31; b >= 0; b--) begin
      if (free[b]) fbit = 5'(b);
    end
    fword     = {row_rd_addr_r, fbit};
    found_idx = IW'(fword);
  end

  assign live = lv_in_r && used_rd_r[lv_bit_r];

  always_comb begin
    sts           = '0;
    sts.act       = act_r;
    sts.kind      = kind_r;
    sts.resched   = resched_r;
    sts.live      = live;
    sts.run_ok    = live && (st_rd_r == ST_RUNNING);
    sts.wait_ok   = live && (st_rd_r >= ST_BLOCKED) && (st_rd_r <= ST_HANGING);
    sts.cnt_zero  = (cnt_r == '0);
    sts.found     = |free;
    sts.scan_last = (scan_cnt_r == SCW'(ROWS));
    sts.clr_done  = (clr_cnt_r == RAW'(ROWS - 1));
    sts.out_busy  = out_valid_r && !out_ready;
  end

  // memory port muxes
  always_comb begin
    used_we    = 1'b0;
    used_waddr = clr_cnt_r;
    used_wdata = '0;
    if (cmd.clr_step) begin
      used_we = 1'b1;
    end else if (cmd.create_commit) begin
      used_we    = 1'b1;
      used_waddr = row_rd_addr_r;
      used_wdata = used_rd_r | (32'd1 << fbit);
    end else if (cmd.exit_commit) begin
      used_we    = 1'b1;
      used_waddr = lv_row_r;
      used_wdata = used_rd_r & ~(32'd1 << lv_bit_r);
    end
    used_re    = cmd.scan_start || cmd.scan_step || cmd.rd_en;
    used_raddr = cmd.scan_start ? '0 : (cmd.scan_step ? scan_cnt_r[RAW-1:0] : lv_row);

    st_we    = 1'b1;
    st_waddr = lv_idx_r;
    st_wdata = ST_READY;
    if (cmd.create_commit) begin
      st_waddr = found_idx;
    end else if (cmd.requeue || cmd.push) begin
      st_wdata = ST_READY;
    end else if (cmd.block_commit) begin
      st_wdata = ST_BLOCKED + {1'b0, kind_r};
    end else if (cmd.exit_commit) begin
      st_wdata = ST_DIED;
    end else if (cmd.pop) begin
      st_waddr = head_r;
      st_wdata = ST_RUNNING;
    end else begin
      st_we = 1'b0;
    end

    tcb_we    = cmd.create_commit || (cmd.requeue && cmd.reload);
    tcb_waddr = cmd.create_commit ? found_idx : lv_idx_r;
    tcb_wdata = cmd.create_commit ? {prio_r, prio_r} : {tcb_rd_r[15:8], tcb_rd_r[15:8]};

    lk_re    = cmd.rd_en || cmd.head_rd;
    lk_raddr = cmd.rd_en ? lv_idx : head_r;
  end

  // ready deque
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    run_nxt   = run_r;
    nx_we     = 1'b0;
    nx_waddr  = tail_r;
    nx_wdata  = '0;
    pv_we     = 1'b0;
    pv_waddr  = head_r;
    pv_wdata  = '0;
    do_append = cmd.create_commit || cmd.requeue;
    app_x     = cmd.create_commit ? found_idx : lv_idx_r;
    if (do_append) begin
      if (cnt_r == '0) begin
        head_nxt = app_x;
      end else begin
        nx_we    = 1'b1;
        nx_waddr = tail_r;
        nx_wdata = app_x;
        pv_we    = 1'b1;
        pv_waddr = app_x;
        pv_wdata = tail_r;
      end
      tail_nxt = app_x;
      cnt_nxt  = cnt_r + CW'(1);
    end else if (cmd.push) begin
      if (cnt_r == '0) begin
        tail_nxt = lv_idx_r;
      end else begin
        pv_we    = 1'b1;
        pv_waddr = head_r;
        pv_wdata = lv_idx_r;
        nx_we    = 1'b1;
        nx_waddr = lv_idx_r;
        nx_wdata = head_r;
      end
      head_nxt = lv_idx_r;
      cnt_nxt  = cnt_r + CW'(1);
    end else if (cmd.exit_commit) begin
      if (st_rd_r == ST_READY && cnt_r != '0) begin
        if (cnt_r != CW'(1)) begin
          if (lv_idx_r == head_r) begin
            head_nxt = nx_rd_r;
          end else if (lv_idx_r == tail_r) begin
            tail_nxt = pv_rd_r;
          end else begin
            nx_we    = 1'b1;
            nx_waddr = pv_rd_r;
            nx_wdata = nx_rd_r;
            pv_we    = 1'b1;
            pv_waddr = nx_rd_r;
            pv_wdata = pv_rd_r;
          end
        end
        cnt_nxt = cnt_r - CW'(1);
      end
      if (run_r == lv_pid_r) run_nxt = '0;
    end else if (cmd.pop) begin
      if (cnt_r != CW'(1)) head_nxt = nx_rd_r;
      cnt_nxt = cnt_r - CW'(1);
      run_nxt = PID_W'(32'(head_r) + 32'd1);
    end else if (cmd.ds_start) begin
      run_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (used_we) used_mem[used_waddr] <= used_wdata;
    if (used_re) used_rd_r <= used_mem[used_raddr];
  end

  always_ff @(posedge clk) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    if (cmd.rd_en) st_rd_r <= st_mem[lv_idx];
  end

  always_ff @(posedge clk) begin
    if (tcb_we) tcb_mem[tcb_waddr] <= tcb_wdata;
    if (cmd.rd_en) tcb_rd_r <= tcb_mem[lv_idx];
  end

  always_ff @(posedge clk) begin
    if (nx_we) nx_mem[nx_waddr] <= nx_wdata;
    if (lk_re) nx_rd_r <= nx_mem[lk_raddr];
  end

  always_ff @(posedge clk) begin
    if (pv_we) pv_mem[pv_waddr] <= pv_wdata;
    if (lk_re) pv_rd_r <= pv_mem[lk_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      clr_cnt_r   <= '0;
      scan_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + RAW'(1);
      if (cmd.scan_start) scan_cnt_r <= SCW'(1);
      else if (cmd.scan_step) scan_cnt_r <= scan_cnt_r + SCW'(1);
      if (cmd.out_load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_r     <= in_data.action;
      tgt_r     <= in_data.target_pid;
      prio_r    <= in_data.priority_req;
      kind_r    <= in_data.block_kind;
      resched_r <= in_data.reschedule;
      cur_r     <= run_r;
    end
    if (cmd.scan_start) row_rd_addr_r <= '0;
    else if (cmd.scan_step) row_rd_addr_r <= scan_cnt_r[RAW-1:0];
    if (cmd.rd_en) begin
      lv_pid_r <= lv_pid;
      lv_idx_r <= lv_idx;
      lv_row_r <= lv_row;
      lv_bit_r <= lv_bit;
      lv_in_r  <= lv_in;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_pid_r  <= (in_data.action == ACT_CREATE) ? '0 : run_r;
      res_prev_r <= '0;
      res_sw_r   <= 1'b0;
      res_out_r  <= (in_data.action == ACT_CREATE) ? OUTC_FULL : OUTC_OK;
    end else if (cmd.create_commit) begin
      res_pid_r <= PID_W'(32'(found_idx) + 32'd1);
      res_out_r <= OUTC_OK;
    end else if (cmd.err) begin
      res_out_r <= OUTC_BAD;
    end else if (cmd.exit_commit) begin
      res_pid_r <= run_nxt;
    end else if (cmd.none_run) begin
      res_pid_r  <= '0;
      res_prev_r <= cur_r;
      res_out_r  <= OUTC_NONE;
    end else if (cmd.pop) begin
      res_pid_r  <= run_nxt;
      res_prev_r <= cur_r;
      res_sw_r   <= 1'b1;
    end
    if (cmd.out_load) begin
      out_data_r.result_pid   <= res_pid_r;
      out_data_r.previous_pid <= res_prev_r;
      out_data_r.switched     <= res_sw_r;
      out_data_r.outcome      <= res_out_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `TSP_ASSERT_NOW(a_cnt_range, 1'b1, cnt_r <= CW'(MAX_TASKS))
  `TSP_ASSERT_NOW(a_exit_ready_queued, cmd.exit_commit && st_rd_r == ST_READY, cnt_r != '0)
  `TSP_ASSERT_NOW(a_pop_nonempty, cmd.head_rd || cmd.pop, cnt_r != '0)
  `TSP_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid_r)

endmodule
`default_nettype wire

FILE: design/task_scheduler_with_pid_pool_top.sv
// Task scheduler with a lowest-free PID pool and a round-robin ready deque.
// in_*: one scheduling command per beat (create, preempt, yield, block,
//   unblock, exit); the block takes it when in_valid and in_ready are high.
// out_*: exactly one result beat per command, in command order.
// psel/penable/pwrite/paddr/pwdata: register 0 at address 0 holds idle_pid;
//   pready is tied high, prdata returns the register.
// Create scans the PID map, ROWS = ceil(MAX_TASKS/32) rows of 32 bits, one
//   row per cycle until a free bit turns up.
// One command at a time; the next is taken in the cycle after the result is
//   loaded into the output register.
// Reset: synchronous, active low; afterwards the PID map is cleared one row
//   per cycle with in_ready low. No task runs and the deque is empty.
// A stalled receiver holds the result in the output register; the block
//   finishes the next command and waits with it until the register frees.
`default_nettype none
module task_scheduler_with_pid_pool_top #(
  parameter int MAX_TASKS = 1024
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire tsp_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tsp_pkg::out_t      out_data,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [2:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tsp_pkg::*;

  cmd_t             cmd;
  sts_t             sts;
  logic [PID_W-1:0] idle_pid_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idle_pid_r <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_IDLE_PID) begin
      idle_pid_r <= pwdata[PID_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_IDLE_PID) ? 32'(idle_pid_r) : '0;

  tsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tsp_dp #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .idle_pid  (idle_pid_r),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
